// File: rtl/upd_pkg.sv
// upd_pkg: types, character constants and the hex digit decoder shared by
// the url percent decoder front end, command queue and output back end
// no dependencies
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int MAX_BYTES = 3;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } held_state_t;

    // bytes produced by one input transaction, oldest in bytes[0]
    typedef struct packed {
        logic [1:0]                 count;
        logic                       last;
        logic [MAX_BYTES-1:0][7:0] bytes;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid  = 1'b0;
        h.nibble = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.valid  = 1'b1;
            h.nibble = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.valid  = 1'b1;
            h.nibble = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// File: rtl/upd_front.sv
// upd_front: holds a pending '%' and first digit, classifies each input byte
// and builds the group of decoded bytes it produces; depends on upd_pkg
`default_nettype none

module upd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output upd_pkg::cmd_t      cmd,
    output logic               cmd_push
);
    import upd_pkg::*;

    held_state_t state_reg, state_next;
    logic [7:0]  held_digit_reg, held_digit_next;

    hex_t       cur_hex;
    hex_t       held_hex;
    logic       fresh_hold;
    logic       fresh_emit;
    logic [7:0] fresh_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= HELD_NONE;
            held_digit_reg <= 8'd0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            held_digit_reg <= held_digit_next;
        end
    end

    always_comb
    begin
        cur_hex    = hex_decode(in_byte);
        held_hex   = hex_decode(held_digit_reg);
        fresh_hold = (in_byte == CH_PERCENT) && !in_last;
        fresh_emit = !fresh_hold;
        fresh_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

        cmd             = '0;
        cmd.last        = in_last;
        state_next      = fresh_hold ? HELD_PCT : HELD_NONE;
        held_digit_next = held_digit_reg;

        case (state_reg)
            HELD_PCT:
            begin
                if (cur_hex.valid && !in_last)
                begin
                    state_next      = HELD_DIGIT;
                    held_digit_next = in_byte;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = fresh_byte;
                    cmd.count    = fresh_emit ? 2'd2 : 2'd1;
                end
            end
            HELD_DIGIT:
            begin
                if (cur_hex.valid)
                begin
                    cmd.bytes[0] = {held_hex.nibble, cur_hex.nibble};
                    cmd.count    = 2'd1;
                    state_next   = HELD_NONE;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = held_digit_reg;
                    cmd.bytes[2] = fresh_byte;
                    cmd.count    = fresh_emit ? 2'd3 : 2'd2;
                end
            end
            default:
            begin
                cmd.bytes[0] = fresh_byte;
                cmd.count    = {1'b0, fresh_emit};
            end
        endcase

        cmd_push = accept && (cmd.count != 2'd0);
    end

    a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> state_reg == HELD_NONE)
        else $error("hold state survives the end of a string");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> cmd_push)
        else $error("final byte produced no output");

endmodule

`default_nettype wire

// File: rtl/upd_cmd_fifo.sv
// upd_cmd_fifo: short flop-based queue of byte groups between the front end
// and the output back end; depends on upd_pkg
`default_nettype none

module upd_cmd_fifo
#(
    parameter int DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire upd_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output upd_pkg::cmd_t      rd_data,
    output logic               empty
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full) && !(rd_en && empty))
        else $error("command queue overflow or underflow");

endmodule

`default_nettype wire

// File: rtl/upd_back.sv
// upd_back: walks the head byte group of the command queue, feeding one byte
// per cycle into the output register when free or popped; depends on upd_pkg
`default_nettype none

module upd_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire upd_pkg::cmd_t head,
    input  wire logic          head_empty,
    output logic               head_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               out_last
);
    import upd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       head_valid;
    logic       at_end;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        head_valid = !head_empty;
        at_end     = (idx_reg == head.count - 2'd1);
        load       = head_valid && (!out_valid_reg || pop);
        head_pop   = load && at_end;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = head.bytes[idx_reg];
            out_last_next  = head.last && at_end;
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head.count != 2'd0) && (idx_reg < head.count))
        else $error("byte index outside the head group");

    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 2'd0)
        else $error("byte index left mid group with the queue empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_byte_reg)
            && $stable(out_last_reg))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder.sv
// url_percent_decoder: top level of the streaming form-urlencoded decoder
// depends on upd_pkg, upd_front, upd_cmd_fifo and upd_back
`default_nettype none

// Decodes an encoded string arriving one byte per transaction, in_last on
// its final byte. "%hh" with two hex digits of either case becomes one byte
// (zero allowed), '+' becomes a space, anything else passes through; a '%'
// without two valid digits is passed through and the following bytes are
// decoded afresh. At in_last any held bytes are flushed and out_last marks
// the final decoded byte. Each input transaction yields 0 to 3 output
// transactions. Bytes that yield at most one result stream at one per clock
// while pop is held, through the command queue and then the output register;
// a transaction that yields k results sends them one at a time through the
// single output register; the input is stalled (full) only once the
// QUEUE_DEPTH entry command queue before the output stage has filled.
module url_percent_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import upd_pkg::*;

    logic accept;
    cmd_t front_cmd;
    logic front_push;
    cmd_t head_cmd;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    upd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cmd      (front_cmd),
        .cmd_push (front_push)
    );

    upd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head_cmd),
        .empty   (head_empty)
    );

    upd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for url_percent_decoder: random and directed encoded strings, with
// decoded bytes predicted in-line and compared against the queue-style output
// depends on upd_pkg and the url_percent_decoder rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_AT = 250;
    localparam int RANDOM_ITEMS = 310;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         drain;
    } enc_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       out_last;

    enc_item_t   enc_q[$];
    dec_byte_t   decoded_q[$];
    held_state_t held = HELD_NONE;
    logic [7:0]  held_chr = 8'h00;

    int  total_items = 0;
    int  offered_cnt = 0;
    int  accepted_cnt = 0;
    int  popped_cnt = 0;
    int  seen_cnt = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  gap_cnt = 0;
    int  rx_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    url_percent_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    always #2 clk = ~clk;

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] b);
        dec_byte_t d;
        d.data = b;
        d.last = 1'b0;
        decoded_q.push_back(d);
    endfunction

    // one byte decoded with nothing held
    function automatic void decode_plain(input logic [7:0] b, input logic last);
        if (b == CH_PERCENT)
        begin
            if (last)
                emit(b);
            else
                held = HELD_PCT;
        end
        else if (b == CH_PLUS)
            emit(CH_SPACE);
        else
            emit(b);
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic last);
        logic [3:0]  lo;
        logic [3:0]  hi;
        bit          lo_ok;
        bit          hi_ok;
        int          n0;
        held_state_t was;
        dec_byte_t   d;
        n0 = decoded_q.size();
        lo_ok = hex_nibble(b, lo);
        was = held;
        held = HELD_NONE;
        case (was)
            HELD_PCT:
            begin
                if (lo_ok && !last)
                begin
                    held_chr = b;
                    held = HELD_DIGIT;
                end
                else
                begin
                    emit(CH_PERCENT);
                    decode_plain(b, last);
                end
            end
            HELD_DIGIT:
            begin
                hi_ok = hex_nibble(held_chr, hi);
                if (lo_ok && hi_ok)
                    emit({hi, lo});
                else
                begin
                    emit(CH_PERCENT);
                    decode_plain(held_chr, 1'b0);
                    held = HELD_NONE;
                    decode_plain(b, last);
                end
                held_chr = 8'h00;
            end
            default:
                decode_plain(b, last);
        endcase
        if (last)
        begin
            held = HELD_NONE;
            held_chr = 8'h00;
            if (decoded_q.size() > n0)
            begin
                d = decoded_q.pop_back();
                d.last = 1'b1;
                decoded_q.push_back(d);
            end
        end
    endfunction

    function automatic logic [7:0] rand_hex_chr();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("A" + r - 10);
        return 8'("a" + r - 16);
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        enc_item_t it;
        it.data = b;
        it.last = last;
        it.drain = (total_items == DRAIN_AT);
        if (total_items >= HOLD_AT - 5 && total_items < HOLD_AT + 40)
            it.gap = 0;
        else if (tx_calm)
            it.gap = 0;
        else
            it.gap = $urandom_range(0, 17);
        enc_q.push_back(it);
        total_items++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], i == s.len() - 1);
    endtask

    // driver: offers pending transactions at the falling edge
    always @(negedge clk)
    begin
        enc_item_t cur;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || accepted_cnt == offered_cnt)
        begin
            if (enc_q.size() == 0)
                push <= 1'b0;
            else if (enc_q[0].drain && decoded_q.size() != 0)
                push <= 1'b0;
            else if (gap_cnt < enc_q[0].gap)
            begin
                push <= 1'b0;
                gap_cnt++;
            end
            else
            begin
                cur = enc_q.pop_front();
                in_byte <= cur.data;
                in_last <= cur.last;
                push <= 1'b1;
                offered_cnt++;
                gap_cnt = 0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (popped_cnt != seen_cnt)
            begin
                seen_cnt = popped_cnt;
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 17);
            end
            if (!hold_done && accepted_cnt >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // monitor: checks output transactions, predicts on input transactions
    always @(posedge clk)
    begin
        dec_byte_t d;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                moved = 1'b1;
                popped_cnt++;
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected transaction: out_byte %h out_last %b", out_byte, out_last);
                    errors++;
                end
                else
                begin
                    d = decoded_q.pop_front();
                    if (out_byte !== d.data)
                    begin
                        $error("out_byte: expected %h, actual %h", d.data, out_byte);
                        errors++;
                    end
                    if (out_last !== d.last)
                    begin
                        $error("out_last: expected %b, actual %b", d.last, out_last);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                accepted_cnt++;
                predict_decode(in_byte, in_last);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] tok[$];
        int         r;
        tx_calm = 1'b0;
        queue_text("+%00%Ff");
        queue_text("%");
        queue_text("%4");
        queue_text("%g%%4z");
        queue_text("% %-");
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        while (total_items < RANDOM_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tok.delete();
            repeat ($urandom_range(1, 6))
            begin
                r = $urandom_range(0, 15);
                if (r <= 6)
                begin
                    tok.push_back(CH_PERCENT);
                    tok.push_back(rand_hex_chr());
                    tok.push_back(rand_hex_chr());
                end
                else if (r == 7)
                    tok.push_back(CH_PLUS);
                else if (r <= 10)
                    tok.push_back(8'($urandom_range(0, 255)));
                else if (r == 11)
                    tok.push_back(CH_PERCENT);
                else if (r == 12)
                begin
                    tok.push_back(CH_PERCENT);
                    tok.push_back(rand_hex_chr());
                end
                else if (r == 13)
                begin
                    tok.push_back(CH_PERCENT);
                    tok.push_back(8'($urandom_range(0, 255)));
                end
                else if (r == 14)
                    tok.push_back(8'("a" + $urandom_range(0, 25)));
                else
                begin
                    tok.push_back(CH_PERCENT);
                    tok.push_back(rand_hex_chr());
                    tok.push_back(8'($urandom_range(0, 255)));
                end
            end
            for (int i = 0; i < tok.size(); i++)
                queue_byte(tok[i], i == tok.size() - 1);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_cnt == total_items && decoded_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
